// File: rtl/mkte_pkg.sv
// Shared types, codes and the letter table for the multi-tap text entry block.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mkte_pkg;

    localparam int LINE_CHARS_DEF = 8;
    localparam int MAX_IDX_W      = 6;

    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_TOGGLE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] ACT_APPEND    = 3'd0;
    localparam logic [2:0] ACT_OVERWRITE = 3'd1;
    localparam logic [2:0] ACT_SHIFT     = 3'd2;
    localparam logic [2:0] ACT_CLEAR     = 3'd3;
    localparam logic [2:0] ACT_TOGGLE    = 3'd4;
    localparam logic [2:0] ACT_IGNORE    = 3'd5;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef logic [7:0] t_char;

    typedef struct packed {
        logic                 we;
        logic                 shift;
        logic                 clear;
        logic [MAX_IDX_W-1:0] idx;
        t_char                data;
    } t_store_cmd;

    typedef struct packed {
        logic [2:0] action;
        t_char      char_code;
        logic [2:0] position;
        logic [3:0] text_length;
        logic       digit_mode;
    } t_result;

    function automatic t_char letter_of(input logic [3:0] key, input logic [1:0] tap);
        logic [23:0] trio;
        case (key)
            4'd1: begin
                trio = ".QZ";
            end
            4'd2: begin
                trio = "ABC";
            end
            4'd3: begin
                trio = "DEF";
            end
            4'd4: begin
                trio = "GHI";
            end
            4'd5: begin
                trio = "JKL";
            end
            4'd6: begin
                trio = "MNO";
            end
            4'd7: begin
                trio = "PRS";
            end
            4'd8: begin
                trio = "TUV";
            end
            4'd9: begin
                trio = "WXY";
            end
            default: begin
                trio = 24'd0;
            end
        endcase
        case (tap)
            2'd0: begin
                return trio[23:16];
            end
            2'd1: begin
                return trio[15:8];
            end
            default: begin
                return trio[7:0];
            end
        endcase
    endfunction

endpackage

`default_nettype wire

// File: rtl/mkte_store.sv
// Line store: LINE_CHARS character cells with write, shift-left-and-write and clear.
// Depends on mkte_pkg for the command struct and the space code.
`timescale 1ns / 1ps
`default_nettype none

module mkte_store #(
    parameter int LINE_CHARS = mkte_pkg::LINE_CHARS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mkte_pkg::t_store_cmd i_cmd
);
    import mkte_pkg::*;

    localparam int IW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

    t_char r_cells [LINE_CHARS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < LINE_CHARS; i++) begin
                r_cells[i] <= CH_SPACE;
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < LINE_CHARS - 1; i++) begin
                r_cells[i] <= r_cells[i+1];
            end
            r_cells[LINE_CHARS-1] <= i_cmd.data;
        end else if (i_cmd.we) begin
            r_cells[i_cmd.idx[IW-1:0]] <= i_cmd.data;
        end
    end

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.we, i_cmd.shift, i_cmd.clear}))
        else $error("store got more than one command");

    a_clear_spaces: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_cells[0] == CH_SPACE) && (r_cells[LINE_CHARS-1] == CH_SPACE))
        else $error("store not blank after clear");

endmodule

`default_nettype wire

// File: rtl/mkte_ctrl.sv
// Entry control: mode, previous key, tap count and fill count, plus the per-beat decode
// that forms the result and the store command. Depends on mkte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkte_ctrl #(
    parameter int LINE_CHARS = mkte_pkg::LINE_CHARS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  wire  [1:0]           i_opcode,
    input  wire  [3:0]           i_key,
    output mkte_pkg::t_result    o_res,
    output mkte_pkg::t_store_cmd o_cmd
);
    import mkte_pkg::*;

    localparam int FW = $clog2(LINE_CHARS + 1);
    localparam int IW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;

    logic          r_mode;
    logic [3:0]    r_prev;
    logic [1:0]    r_tap;
    logic [FW-1:0] r_fill;

    logic          n_mode;
    logic [3:0]    n_prev;
    logic [1:0]    n_tap;
    logic [FW-1:0] n_fill;

    logic          key_ok;
    logic          do_append;
    logic [1:0]    tap_inc;
    t_char         ch;
    logic [IW-1:0] pos;
    logic [2:0]    act;
    t_store_cmd    cmd;

    assign key_ok  = (i_key >= 4'd1) && (i_key <= 4'd9);
    assign tap_inc = (r_tap == 2'd2) ? 2'd0 : r_tap + 2'd1;

    always_comb begin
        n_mode    = r_mode;
        n_prev    = r_prev;
        n_tap     = r_tap;
        n_fill    = r_fill;
        do_append = 1'b0;
        ch        = '0;
        pos       = '0;
        act       = ACT_IGNORE;
        cmd       = '0;
        case (i_opcode)
            OP_TOGGLE: begin
                n_mode = ~r_mode;
                n_tap  = 2'd0;
                n_prev = 4'd0;
                act    = ACT_TOGGLE;
            end
            OP_CLEAR: begin
                cmd.clear = 1'b1;
                n_fill    = '0;
                n_tap     = 2'd0;
                n_prev    = 4'd0;
                act       = ACT_CLEAR;
            end
            OP_KEY: begin
                if (key_ok) begin
                    n_prev = i_key;
                    if (r_mode) begin
                        ch        = CH_ZERO + {4'd0, i_key};
                        do_append = 1'b1;
                    end else if (r_prev == i_key && r_fill != '0) begin
                        n_tap    = tap_inc;
                        ch       = letter_of(i_key, tap_inc);
                        pos      = IW'(r_fill - FW'(1));
                        cmd.we   = 1'b1;
                        cmd.idx  = MAX_IDX_W'(pos);
                        cmd.data = ch;
                        act      = ACT_OVERWRITE;
                    end else begin
                        n_tap     = 2'd0;
                        ch        = letter_of(i_key, 2'd0);
                        do_append = 1'b1;
                    end
                end
            end
            default: begin
                act = ACT_IGNORE;
            end
        endcase
        if (do_append) begin
            cmd.data = ch;
            if (r_fill == FW'(LINE_CHARS)) begin
                cmd.shift = 1'b1;
                pos       = IW'(LINE_CHARS - 1);
                act       = ACT_SHIFT;
            end else begin
                pos     = IW'(r_fill);
                cmd.we  = 1'b1;
                cmd.idx = MAX_IDX_W'(pos);
                n_fill  = r_fill + FW'(1);
                act     = ACT_APPEND;
            end
        end
    end

    assign o_res.action      = act;
    assign o_res.char_code   = ch;
    assign o_res.position    = 3'(pos);
    assign o_res.text_length = 4'(n_fill);
    assign o_res.digit_mode  = n_mode;

    assign o_cmd.we    = cmd.we & i_fire;
    assign o_cmd.shift = cmd.shift & i_fire;
    assign o_cmd.clear = cmd.clear & i_fire;
    assign o_cmd.idx   = cmd.idx;
    assign o_cmd.data  = cmd.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_prev <= 4'd0;
            r_tap  <= 2'd0;
            r_fill <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_prev <= n_prev;
            r_tap  <= n_tap;
            r_fill <= n_fill;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(LINE_CHARS))
        else $error("fill count past line length");

    a_tap_mod3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tap != 2'd3)
        else $error("tap count out of range");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_opcode == OP_CLEAR) |=> (r_fill == '0) && (r_prev == 4'd0))
        else $error("clear did not reset line state");

endmodule

`default_nettype wire

// File: rtl/mkte_outq.sv
// Two-entry result queue between the decode and the output channel.
// Depends on mkte_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module mkte_outq (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  mkte_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    input  wire               i_stall,
    output mkte_pkg::t_result o_data
);
    import mkte_pkg::*;

    t_result    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;

    always_comb begin
        case ({i_push, pop})
            2'b10: begin
                n_count = r_count + 2'd1;
            end
            2'b01: begin
                n_count = r_count - 2'd1;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == 2'd2))
        else $error("push into full result queue");

endmodule

`default_nettype wire

// File: rtl/multitap_keypad_text_entry.sv
// Multi-tap keypad text entry, top level: input register, entry control, line store,
// result queue. Depends on mkte_pkg, mkte_ctrl, mkte_store and mkte_outq.
//
//   channel | dir | handshake               | beat fields
//   --------+-----+-------------------------+---------------------------------------------
//   in      | in  | i_in_valid / o_in_stall | i_opcode, i_key_number
//   out     | out | o_out_valid/ i_out_stall| o_action, o_char_code, o_position,
//           |     |                         | o_text_length, o_digit_mode
//
// One beat per cycle sustained while the output is not stalled; a result passes through
// the input register, then is decoded into the result queue.
// Reset: synchronous, active low; letter mode, empty line, store all spaces.
// A stalled output fills the two-entry queue, then the input register holds and
// o_in_stall rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module multitap_keypad_text_entry #(
    parameter int LINE_CHARS = mkte_pkg::LINE_CHARS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire  [1:0] i_opcode,
    input  wire  [3:0] i_key_number,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [2:0] o_action,
    output logic [7:0] o_char_code,
    output logic [2:0] o_position,
    output logic [3:0] o_text_length,
    output logic       o_digit_mode
);
    import mkte_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_opcode;
    logic [3:0] r_key;

    logic       in_acc;
    logic       fire;
    logic       q_ready;
    t_result    res;
    t_result    q_data;
    t_store_cmd cmd;

    assign fire       = r_in_valid && q_ready;
    assign o_in_stall = r_in_valid && !q_ready;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_opcode <= i_opcode;
            r_key    <= i_key_number;
        end
    end

    mkte_ctrl #(
        .LINE_CHARS(LINE_CHARS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_opcode (r_opcode),
        .i_key    (r_key),
        .o_res    (res),
        .o_cmd    (cmd)
    );

    mkte_store #(
        .LINE_CHARS(LINE_CHARS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd)
    );

    mkte_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_data  (res),
        .o_ready (q_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (q_data)
    );

    assign o_action      = q_data.action;
    assign o_char_code   = q_data.char_code;
    assign o_position    = q_data.position;
    assign o_text_length = q_data.text_length;
    assign o_digit_mode  = q_data.digit_mode;

endmodule

`default_nettype wire
